>>> hdl/logistic_regression_predict_macros.svh
// assertion helpers used by lrp_back
`ifndef LOGISTIC_REGRESSION_PREDICT_MACROS_SVH
`define LOGISTIC_REGRESSION_PREDICT_MACROS_SVH

// same-cycle implication
`define LRP_ASSERT_IMPL(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("lrp assertion failed");

// next-cycle implication
`define LRP_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("lrp assertion failed");

`endif

>>> hdl/lrp_pkg.sv
package lrp_pkg;

    localparam int MAX_FEATURES   = 64;
    localparam int VALUE_WIDTH    = 16;
    localparam int SIG_DEPTH      = 256;
    localparam int SIG_DEPTH_LOG2 = $clog2(SIG_DEPTH);
    localparam int INDEX_WIDTH    = 6;
    localparam int ADDR_WIDTH     = $clog2(MAX_FEATURES);
    localparam int COUNT_WIDTH    = 7;
    localparam int ACC_WIDTH      = 40;
    localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;
    localparam int PROB_WIDTH     = 16;
    localparam int STATUS_WIDTH   = 2;
    // |eta| of 8.0 with 24 fraction bits
    localparam int ETA_SAT_BIT    = 27;
    localparam int IDX_SHIFT      = ETA_SAT_BIT - SIG_DEPTH_LOG2;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_WIDTH    = $clog2(Q_DEPTH);
    localparam int Q_COUNT_WIDTH  = $clog2(Q_DEPTH + 1);
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FITTED  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_MISMATCH    = 2'd2;

    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_NUM_FEATURES = 3'd0;
    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_MODEL_FITTED = 3'd4;
    localparam int REG_SEL_BIT = 2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX         = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] NUM_FEATURES_RST  = 7'd1;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [SIG_DEPTH_LOG2-1:0] SIG_IDX_MAX = {SIG_DEPTH_LOG2{1'b1}};
    localparam logic [PROB_WIDTH:0] PROB_ONE = {1'b1, {PROB_WIDTH{1'b0}}};
    localparam logic [PROB_WIDTH-1:0] PROB_MIN = 16'd1;
    localparam logic [PROB_WIDTH-1:0] PROB_MAX = {PROB_WIDTH{1'b1}};

    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic signed [VALUE_WIDTH-1:0] coef;
        logic                          last;
    } lrp_feat_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] num_features;
        logic                   model_fitted;
    } lrp_cfg_t;

    typedef logic [PROB_WIDTH:0] sig_entry_t;
    typedef sig_entry_t sig_table_t [SIG_DEPTH];

    // shift and subtract quotient, non-negative operands
    function automatic longint udiv_const(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            if (r >= den)
            begin
                r = r - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // 1 / (1 + exp(-x)) in q0.16 for x = 8 * i / depth
    function automatic sig_entry_t sig_entry(input int i);
        longint y;
        longint term;
        longint e;
        longint d;
        longint p;
        y    = (longint'(i) <<< 30) >>> SIG_DEPTH_LOG2;
        term = ONE_Q30;
        e    = ONE_Q30;
        for (int k = 1; k <= 16; k++)
        begin
            term = udiv_const((term * y) >>> 30, longint'(k));
            if ((k % 2) == 1)
                e = e - term;
            else
                e = e + term;
        end
        if (e < 0)
            e = 0;
        if (e > ONE_Q30)
            e = ONE_Q30;
        for (int k = 0; k < 3; k++)
        begin
            e = (e * e) >>> 30;
        end
        d = ONE_Q30 + e;
        p = udiv_const((64'sd1 <<< 46) + (d >>> 1), d);
        return sig_entry_t'(p);
    endfunction

    function automatic sig_table_t sig_table_build();
        sig_table_t t;
        for (int i = 0; i < SIG_DEPTH; i++)
        begin
            t[i] = sig_entry(i);
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = sig_table_build();

endpackage

>>> hdl/lrp_if.sv
interface lrp_item_if
    import lrp_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [INDEX_WIDTH-1:0]        feature_index;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last_feature;

    modport source (output valid, opcode, feature_index, value, last_feature, input ready);
    modport sink (input valid, opcode, feature_index, value, last_feature, output ready);
endinterface

interface lrp_result_if
    import lrp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [PROB_WIDTH-1:0]   probability;
    logic                    predicted_class;
    logic [STATUS_WIDTH-1:0] status;

    modport source (output valid, probability, predicted_class, status, input ready);
    modport sink (input valid, probability, predicted_class, status, output ready);
endinterface

>>> hdl/logistic_regression_predict.sv
// result path: a row's last feature word passes the front stage, queue, multiply,
// accumulate, index and output registers; throughput: one load or feature word per
// cycle unless the queue is full, limited by the accumulate loop; loads give no result
// reset: rst_n asynchronous, clears pipeline, queue, accumulator and row count,
// sets num_features to 1 and model_fitted to 0; coefficient memory is not cleared
module logistic_regression_predict
    import lrp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    lrp_item_if.sink                  items,
    lrp_result_if.source              results,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    lrp_cfg_t  cfg;
    logic      q_full;
    logic      q_push;
    lrp_feat_t q_push_data;
    logic      q_pop;
    logic      q_valid;
    lrp_feat_t q_pop_data;

    lrp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lrp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    lrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    lrp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule

>>> hdl/lrp_regs.sv
module lrp_regs
    import lrp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output lrp_cfg_t                  cfg
);

    lrp_cfg_t cfg_reg;
    lrp_cfg_t cfg_next;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register select on the word address bit
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            if (paddr[REG_SEL_BIT])
                cfg_next.model_fitted = pwdata[0];
            else
                cfg_next.num_features = pwdata[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_features <= NUM_FEATURES_RST;
            cfg_reg.model_fitted <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_NUM_FEATURES: prdata = APB_DATA_WIDTH'(cfg_reg.num_features);
            ADDR_MODEL_FITTED: prdata = APB_DATA_WIDTH'(cfg_reg.model_fitted);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/lrp_front.sv
module lrp_front
    import lrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lrp_item_if.sink   items,
    input  logic       q_full,
    output logic       q_push,
    output lrp_feat_t  q_push_data
);

    logic signed [VALUE_WIDTH-1:0] coef_mem [MAX_FEATURES];
    logic signed [VALUE_WIDTH-1:0] coef_rd_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic                          last_reg;
    logic                          in_range_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          accept;
    logic                          is_feature;
    logic                          in_range;
    logic [ADDR_WIDTH-1:0]         addr;

    assign accept     = items.valid && items.ready;
    assign is_feature = (items.opcode == OP_FEATURE);
    assign in_range   = (int'(items.feature_index) < MAX_FEATURES);
    assign addr       = items.feature_index[ADDR_WIDTH-1:0];

    assign items.ready = !s1_valid_reg || !q_full;
    assign q_push      = s1_valid_reg && !q_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (q_push)
            s1_valid_next = 1'b0;
        if (accept && is_feature)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // coefficient store, registered read
    always_ff @(posedge clk)
    begin
        if (accept && !is_feature && in_range)
            coef_mem[addr] <= items.value;
        if (accept && is_feature)
            coef_rd_reg <= coef_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_feature)
        begin
            value_reg    <= items.value;
            last_reg     <= items.last_feature;
            in_range_reg <= in_range;
        end
    end

    always_comb
    begin
        q_push_data.value = value_reg;
        q_push_data.coef  = in_range_reg ? coef_rd_reg : '0;
        q_push_data.last  = last_reg;
    end

endmodule

>>> hdl/lrp_queue.sv
module lrp_queue
    import lrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lrp_feat_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output lrp_feat_t pop_data
);

    lrp_feat_t                q_mem_reg [Q_DEPTH];
    logic [Q_PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [Q_PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [Q_COUNT_WIDTH-1:0] count_reg;
    logic [Q_COUNT_WIDTH-1:0] count_next;

    assign full     = (count_reg == Q_COUNT_WIDTH'(Q_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hdl/lrp_back.sv
`include "logistic_regression_predict_macros.svh"

module lrp_back
    import lrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lrp_cfg_t    cfg,
    input  logic        q_valid,
    input  lrp_feat_t   q_data,
    output logic        q_pop,
    lrp_result_if.source results
);

    logic                           adv;

    // multiply stage
    logic                           m_valid_reg;
    logic                           m_last_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;

    // accumulate stage
    logic [ACC_WIDTH-1:0]           acc_reg;
    logic [ACC_WIDTH-1:0]           acc_next;
    logic [COUNT_WIDTH-1:0]         count_reg;
    logic [COUNT_WIDTH-1:0]         count_next;
    logic [COUNT_WIDTH-1:0]         count_inc;
    logic [ACC_WIDTH:0]             sum_wide;
    logic [ACC_WIDTH-1:0]           acc_sat;
    logic [STATUS_WIDTH-1:0]        row_status;
    logic                           a_valid_reg;
    logic [ACC_WIDTH-1:0]           a_eta_reg;
    logic [STATUS_WIDTH-1:0]        a_status_reg;

    // index stage
    logic [ACC_WIDTH-1:0]           mag;
    logic [SIG_DEPTH_LOG2-1:0]      idx;
    logic                           i_valid_reg;
    logic                           i_neg_reg;
    logic [SIG_DEPTH_LOG2-1:0]      i_idx_reg;
    logic [STATUS_WIDTH-1:0]        i_status_reg;

    // output stage
    sig_entry_t                     entry;
    logic [PROB_WIDTH:0]            p_signed;
    logic [PROB_WIDTH-1:0]          p_clamped;
    logic                           res_valid_reg;
    logic [PROB_WIDTH-1:0]          res_prob_reg;
    logic                           res_class_reg;
    logic [STATUS_WIDTH-1:0]        res_status_reg;

    assign adv   = !res_valid_reg || results.ready;
    assign q_pop = adv && q_valid;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= $signed(q_data.value) * $signed(q_data.coef);
            m_last_reg <= q_data.last;
        end
    end

    // saturating accumulate, the accumulator feeds itself on each product taken while the pipeline advances
    always_comb
    begin
        sum_wide = {acc_reg[ACC_WIDTH-1], acc_reg}
                 + {{(ACC_WIDTH + 1 - PROD_WIDTH){prod_reg[PROD_WIDTH-1]}}, prod_reg};
        if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1])
            acc_sat = sum_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        else
            acc_sat = sum_wide[ACC_WIDTH-1:0];

        count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

        if (!cfg.model_fitted)
            row_status = STATUS_NOT_FITTED;
        else if (count_inc != cfg.num_features)
            row_status = STATUS_MISMATCH;
        else
            row_status = STATUS_OK;

        acc_next   = acc_reg;
        count_next = count_reg;
        if (adv && m_valid_reg)
        begin
            acc_next   = m_last_reg ? '0 : acc_sat;
            count_next = m_last_reg ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_eta_reg    <= acc_sat;
            a_status_reg <= row_status;
        end
    end

    always_comb
    begin
        mag = a_eta_reg[ACC_WIDTH-1] ? -a_eta_reg : a_eta_reg;
        if (|mag[ACC_WIDTH-1:ETA_SAT_BIT])
            idx = SIG_IDX_MAX;
        else
            idx = mag[ETA_SAT_BIT-1:IDX_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_neg_reg    <= a_eta_reg[ACC_WIDTH-1];
            i_idx_reg    <= idx;
            i_status_reg <= a_status_reg;
        end
    end

    // negative eta mirrors the table
    always_comb
    begin
        entry    = SIG_TABLE[i_idx_reg];
        p_signed = i_neg_reg ? (PROB_ONE - entry) : entry;
        if (p_signed == '0)
            p_clamped = PROB_MIN;
        else if (p_signed[PROB_WIDTH])
            p_clamped = PROB_MAX;
        else
            p_clamped = p_signed[PROB_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_status_reg <= i_status_reg;
            if (i_status_reg == STATUS_OK)
            begin
                res_prob_reg  <= p_clamped;
                res_class_reg <= !i_neg_reg;
            end
            else
            begin
                res_prob_reg  <= '0;
                res_class_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            acc_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (adv)
            begin
                m_valid_reg   <= q_valid;
                a_valid_reg   <= m_valid_reg && m_last_reg;
                i_valid_reg   <= a_valid_reg;
                res_valid_reg <= i_valid_reg;
            end
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    assign results.valid           = res_valid_reg;
    assign results.probability     = res_prob_reg;
    assign results.predicted_class = res_class_reg;
    assign results.status          = res_status_reg;

    `LRP_ASSERT_IMPL(a_err_zero, clk, rst_n, results.valid && (results.status != STATUS_OK), (results.probability == '0) && !results.predicted_class)
    `LRP_ASSERT_IMPL(a_ok_nonzero, clk, rst_n, results.valid && (results.status == STATUS_OK), results.probability != '0)
    `LRP_ASSERT_NEXT(a_row_clear, clk, rst_n, adv && m_valid_reg && m_last_reg, (acc_reg == '0) && (count_reg == '0))

endmodule
